### src/rm2q_pkg.sv
package rm2q_pkg;

    localparam int DataW    = 16;
    localparam int NumW     = 17;
    localparam int RadW     = 30;
    localparam int RootW    = 15;
    localparam int RemW     = 19;
    localparam int SqSteps  = 15;
    localparam int DivSteps = 16;

    // Quaternion component slots
    localparam logic [1:0] SLOT_W = 2'd0;
    localparam logic [1:0] SLOT_X = 2'd1;
    localparam logic [1:0] SLOT_Y = 2'd2;
    localparam logic [1:0] SLOT_Z = 2'd3;

    localparam logic signed [18:0] ONE_Q14 = 19'sd16384;
    localparam logic [15:0] SAT_POS = 16'h7fff;
    localparam logic [15:0] SAT_NEG = 16'h8000;

    typedef struct packed {
        logic [RadW-1:0]           rad;
        logic [RootW-1:0]          root;
        logic [RemW-1:0]           rem;
        logic                      pos;
        logic [1:0]                slot;
        logic [3:0][NumW-1:0]      num;
    } sq_t;

    typedef struct packed {
        logic [15:0] rem;
        logic [15:0] low;
        logic [15:0] quo;
        logic        sat;
        logic        neg;
        logic        nz;
    } lane_t;

    typedef struct packed {
        logic [15:0]      den;
        logic [RootW-1:0] root;
        logic [1:0]       slot;
        lane_t [3:0]      lane;
    } dv_t;

endpackage

### src/rotation_matrix_to_quaternion_core.sv
// Throughput: one matrix per cycle unless m_axis stalls the output; a 15-step
// square root pipeline and four 16-step divider lanes each retire one bit per stage.
// Reset: rst_n clears all valid bits asynchronously; payload registers hold
// whatever they last had and are never presented without a valid bit.
module rotation_matrix_to_quaternion_core
    import rm2q_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22 (16 bits each, lowest first)
    input  logic [143:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // qw, qx, qy, qz (16 bits each, lowest first)
    output logic [63:0]  m_axis_tdata
);

    localparam int NStage = 1 + SqSteps + 1 + DivSteps + 1;
    localparam int Last   = NStage - 1;

    logic [NStage-1:0] vld_reg;
    logic              adv;

    sq_t   sq_reg  [0:SqSteps];
    sq_t   sq_next [0:SqSteps];
    dv_t   dv_reg  [0:DivSteps];
    dv_t   dv_next [0:DivSteps];
    logic [63:0] out_reg;
    logic [63:0] out_next;

    // The whole pipeline moves together; it only holds when the output
    // register is full and the sink is not taking it.
    assign adv           = !vld_reg[Last] || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = vld_reg[Last];
    assign m_axis_tdata  = out_reg;

    // Front stage: trace test, axis pick, radicand and numerators.
    logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic signed [18:0] trace, sum, a;
    logic signed [NumW-1:0] nw, nx, ny, nz;
    logic [1:0] slot;

    always_comb
    begin
        m00 = s_axis_tdata[15:0];
        m01 = s_axis_tdata[31:16];
        m02 = s_axis_tdata[47:32];
        m10 = s_axis_tdata[63:48];
        m11 = s_axis_tdata[79:64];
        m12 = s_axis_tdata[95:80];
        m20 = s_axis_tdata[111:96];
        m21 = s_axis_tdata[127:112];
        m22 = s_axis_tdata[143:128];
        trace = 19'(m00) + 19'(m11) + 19'(m22);
        nw = '0;
        nx = '0;
        ny = '0;
        nz = '0;
        if (trace > 19'sd0)
        begin
            slot = SLOT_W;
            sum  = trace;
            nx   = NumW'(m21) - NumW'(m12);
            ny   = NumW'(m02) - NumW'(m20);
            nz   = NumW'(m10) - NumW'(m01);
        end
        else if ((m00 < m11) ? (m11 < m22) : (m00 < m22))
        begin
            slot = SLOT_Z;
            sum  = 19'(m22) - 19'(m00) - 19'(m11);
            nw   = NumW'(m10) - NumW'(m01);
            nx   = NumW'(m02) + NumW'(m20);
            ny   = NumW'(m12) + NumW'(m21);
        end
        else if (m00 < m11)
        begin
            slot = SLOT_Y;
            sum  = 19'(m11) - 19'(m22) - 19'(m00);
            nw   = NumW'(m02) - NumW'(m20);
            nz   = NumW'(m21) + NumW'(m12);
            nx   = NumW'(m01) + NumW'(m10);
        end
        else
        begin
            slot = SLOT_X;
            sum  = 19'(m00) - 19'(m11) - 19'(m22);
            nw   = NumW'(m21) - NumW'(m12);
            ny   = NumW'(m10) + NumW'(m01);
            nz   = NumW'(m20) + NumW'(m02);
        end
        a = sum + ONE_Q14;
        sq_next[0].pos    = a > 19'sd0;
        sq_next[0].rad    = sq_next[0].pos ? {1'b0, a[16:0], 12'b0} : '0;
        sq_next[0].root   = '0;
        sq_next[0].rem    = '0;
        sq_next[0].slot   = slot;
        sq_next[0].num[0] = nw;
        sq_next[0].num[1] = nx;
        sq_next[0].num[2] = ny;
        sq_next[0].num[3] = nz;
    end

    // Square root: one result bit per stage, top bit pair first.
    for (genvar s = 1; s <= SqSteps; s++)
    begin : g_sq
        localparam int Pair = SqSteps - s;
        logic [RemW-1:0] remn, trial;
        always_comb
        begin
            remn  = {sq_reg[s-1].rem[RemW-3:0], sq_reg[s-1].rad[2*Pair+1 -: 2]};
            trial = {2'b00, sq_reg[s-1].root, 2'b01};
            sq_next[s] = sq_reg[s-1];
            if (remn >= trial)
            begin
                sq_next[s].rem  = remn - trial;
                sq_next[s].root = {sq_reg[s-1].root[RootW-2:0], 1'b1};
            end
            else
            begin
                sq_next[s].rem  = remn;
                sq_next[s].root = {sq_reg[s-1].root[RootW-2:0], 1'b0};
            end
        end
    end

    // Divider setup: dividend = |num|*8192 + p, divisor = 2p (rounds half up).
    logic [RootW-1:0] p;
    always_comb
    begin
        p = sq_reg[SqSteps].pos ? sq_reg[SqSteps].root : '0;
        dv_next[0].den  = {p, 1'b0};
        dv_next[0].root = p;
        dv_next[0].slot = sq_reg[SqSteps].slot;
    end

    for (genvar l = 0; l < 4; l++)
    begin : g_setup
        logic signed [NumW-1:0] n;
        logic [NumW-1:0] mag;
        logic [RadW-1:0] dd;
        always_comb
        begin
            n   = sq_reg[SqSteps].num[l];
            mag = (n < 0) ? NumW'(-n) : NumW'(n);
            dd  = {mag, 13'b0} + RadW'(p);
            dv_next[0].lane[l].neg = n < 0;
            dv_next[0].lane[l].nz  = n != 0;
            dv_next[0].lane[l].sat = (p == '0) || ({2'b00, dd[29:16]} >= {p, 1'b0});
            dv_next[0].lane[l].rem = {2'b00, dd[29:16]};
            dv_next[0].lane[l].low = dd[15:0];
            dv_next[0].lane[l].quo = '0;
        end
    end

    // Restoring division: one quotient bit per stage for each lane.
    for (genvar s = 1; s <= DivSteps; s++)
    begin : g_div
        for (genvar l = 0; l < 4; l++)
        begin : g_lane
            logic [16:0] t;
            logic        ge;
            always_comb
            begin
                t  = {dv_reg[s-1].lane[l].rem, dv_reg[s-1].lane[l].low[15]};
                ge = t >= {1'b0, dv_reg[s-1].den};
                dv_next[s].lane[l]     = dv_reg[s-1].lane[l];
                dv_next[s].lane[l].rem = ge ? 16'(t - {1'b0, dv_reg[s-1].den}) : t[15:0];
                dv_next[s].lane[l].low = {dv_reg[s-1].lane[l].low[14:0], 1'b0};
                dv_next[s].lane[l].quo = {dv_reg[s-1].lane[l].quo[14:0], ge};
            end
        end
        always_comb
        begin
            dv_next[s].den  = dv_reg[s-1].den;
            dv_next[s].root = dv_reg[s-1].root;
            dv_next[s].slot = dv_reg[s-1].slot;
        end
    end

    // Output stage: place the root, apply sign and saturation to the others.
    for (genvar l = 0; l < 4; l++)
    begin : g_out
        lane_t ln;
        always_comb
        begin
            ln = dv_reg[DivSteps].lane[l];
            if (dv_reg[DivSteps].slot == 2'(l))
                out_next[16*l +: 16] = {1'b0, dv_reg[DivSteps].root};
            else if (ln.sat)
                out_next[16*l +: 16] = !ln.nz ? 16'h0000 : (ln.neg ? SAT_NEG : SAT_POS);
            else if (ln.neg)
                out_next[16*l +: 16] = (ln.quo > SAT_NEG) ? SAT_NEG : 16'(-ln.quo);
            else
                out_next[16*l +: 16] = (ln.quo > SAT_POS) ? SAT_POS : ln.quo;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NStage-2:0], s_axis_tvalid};
        end
    end

    // Payload advances with the valid bits; no reset needed.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int s = 0; s <= SqSteps; s++)
            begin
                sq_reg[s] <= sq_next[s];
            end
            for (int s = 0; s <= DivSteps; s++)
            begin
                dv_reg[s] <= dv_next[s];
            end
            out_reg <= out_next;
        end
    end

endmodule
